// File: rtl/bprd_pkg.sv
// Shared types and constants for the button press repeat detector.
package bprd_pkg;

  // Configuration register reset values, in milliseconds
  localparam logic [15:0] PressHoldReset   = 16'd50;
  localparam logic [15:0] RepeatDelayReset = 16'd1000;
  localparam logic [15:0] RepeatPeriodReset = 16'd100;

  // Configuration register indexes (word address)
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] REG_PRESS_HOLD    = 2'd0;
  localparam logic [RegIdxW-1:0] REG_REPEAT_DELAY  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_REPEAT_PERIOD = 2'd2;

  // Event and status flag positions
  localparam int unsigned EVT_CLICKED  = 0;
  localparam int unsigned EVT_RELEASED = 1;
  localparam int unsigned EVT_REPEATED = 2;
  localparam int unsigned ST_PRESSED   = 0;
  localparam int unsigned ST_RELEASED  = 1;
  localparam int unsigned ST_REPEATED  = 2;

  // Button phase
  typedef enum logic [2:0] {
    PH_WAIT_REL  = 3'd0,
    PH_WAIT_PRS  = 3'd1,
    PH_QUALIFY   = 3'd2,
    PH_REP_DELAY = 3'd3,
    PH_REPEAT    = 3'd4
  } phase_t;

endpackage

// File: rtl/button_press_repeat_detector.sv
// Button press qualifier with auto-repeat: input stage, step logic, result stage.
//
// Each item is one poll of the button: its pressed level, a 32-bit millisecond
// timestamp and event clear controls. The block takes one item per clock while
// in_ready is high. An item is held in the input register and then stepped into
// the result register, from which its result is offered. The phase machine
// and its time mark advance once per item, so items may arrive in every cycle.
// in_ready drops only while both the input register and the result register are
// full and out_ready is low. Hold, repeat delay and repeat period sit in APB
// registers at byte addresses 0, 4 and 8 (16 bits each); the user must write them
// only while no item is in flight, as the block itself does not enforce this.
module button_press_repeat_detector (
  input  logic        clk,
  input  logic        rst,
  // Poll items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pressed_level,
  input  logic [31:0] now_ms,
  input  logic        clear_all,
  input  logic [2:0]  clear_mask,
  // Results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        click_fired,
  output logic [2:0]  event_bits,
  output logic [2:0]  status_bits,
  output logic [7:0]  clicks,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bprd_pkg::*;

  logic [15:0] press_hold_ms;
  logic [15:0] repeat_delay_ms;
  logic [15:0] repeat_period_ms;

  logic        s1_valid;
  logic        s1_level;
  logic [31:0] s1_now;
  logic        s1_clear_all;
  logic [2:0]  s1_clear_mask;
  logic        advance;

  phase_t      phase, phase_next;
  logic [31:0] time_mark, time_mark_next;
  logic [2:0]  event_store, event_store_next;
  logic [2:0]  status_store, status_store_next;
  logic [7:0]  click_total, click_total_next;
  logic        fired;
  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        reached;

  // Combined clear: clear_all wipes every event, else the mask picks bits
  function automatic logic [2:0] clear_mask_eff(input logic all_bits, input logic [2:0] mask);
    return all_bits ? 3'b111 : mask;
  endfunction

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_hold_ms    <= PressHoldReset;
      repeat_delay_ms  <= RepeatDelayReset;
      repeat_period_ms <= RepeatPeriodReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PRESS_HOLD:    press_hold_ms    <= pwdata[15:0];
        REG_REPEAT_DELAY:  repeat_delay_ms  <= pwdata[15:0];
        REG_REPEAT_PERIOD: repeat_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PRESS_HOLD:    prdata = {16'd0, press_hold_ms};
      REG_REPEAT_DELAY:  prdata = {16'd0, repeat_delay_ms};
      REG_REPEAT_PERIOD: prdata = {16'd0, repeat_period_ms};
      default:           prdata = 32'd0;
    endcase
  end

  // Flow control: step the held item when the result register can take it
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level      <= pressed_level;
      s1_now        <= now_ms;
      s1_clear_all  <= clear_all;
      s1_clear_mask <= clear_mask;
    end
  end

  // Deadline check against the stored mark, 32-bit wrap
  assign elapsed = s1_now - time_mark;
  always_comb begin
    case (phase)
      PH_QUALIFY:   limit = press_hold_ms;
      PH_REP_DELAY: limit = repeat_delay_ms;
      default:      limit = repeat_period_ms;
    endcase
  end
  assign reached = elapsed >= {16'd0, limit};

  // Step: apply clears, then run the phase machine
  always_comb begin
    phase_next        = phase;
    time_mark_next    = time_mark;
    status_store_next = status_store;
    click_total_next  = click_total;
    fired             = 1'b0;
    event_store_next  = event_store & ~clear_mask_eff(s1_clear_all, s1_clear_mask);

    unique case (phase)
      PH_WAIT_REL: begin
        if (!s1_level) phase_next = PH_WAIT_PRS;
      end
      PH_WAIT_PRS: begin
        if (s1_level) begin
          phase_next       = PH_QUALIFY;
          time_mark_next   = s1_now;
          click_total_next = 8'd0;
        end
      end
      PH_QUALIFY: begin
        if (s1_level) begin
          if (reached) begin
            fired                          = 1'b1;
            phase_next                     = PH_REP_DELAY;
            time_mark_next                 = s1_now;
            event_store_next[EVT_CLICKED]  = 1'b1;
            status_store_next[ST_PRESSED]  = 1'b1;
            click_total_next               = click_total + 8'd1;
          end
        end else begin
          phase_next = PH_WAIT_PRS;
          if (status_store[ST_PRESSED]) begin
            event_store_next[EVT_RELEASED] = 1'b1;
            status_store_next[ST_RELEASED] = 1'b1;
            status_store_next[ST_PRESSED]  = 1'b0;
            status_store_next[ST_REPEATED] = 1'b0;
          end
        end
      end
      PH_REP_DELAY, PH_REPEAT: begin
        if (s1_level) begin
          if (reached) begin
            fired                          = 1'b1;
            phase_next                     = PH_REPEAT;
            time_mark_next                 = s1_now;
            event_store_next[EVT_CLICKED]  = 1'b1;
            event_store_next[EVT_REPEATED] = 1'b1;
            status_store_next[ST_REPEATED] = 1'b1;
            click_total_next               = click_total + 8'd1;
          end
        end else begin
          phase_next     = PH_QUALIFY;
          time_mark_next = s1_now;
        end
      end
      default: begin
        phase_next = PH_WAIT_REL;
      end
    endcase
  end

  // State registers advance once per stepped item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_REL;
      time_mark    <= 32'd0;
      event_store  <= 3'd0;
      status_store <= 3'd0;
      click_total  <= 8'd0;
    end else if (advance) begin
      phase        <= phase_next;
      time_mark    <= time_mark_next;
      event_store  <= event_store_next;
      status_store <= status_store_next;
      click_total  <= click_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      click_fired <= fired;
      event_bits  <= event_store_next;
      status_bits <= status_store_next;
      clicks      <= click_total_next;
    end
  end

endmodule

// File: rtl/bprd_checker.sv
// Port-level checks for the button press repeat detector, bound to the top level.
module bprd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       click_fired,
  input logic [2:0] event_bits,
  input logic [2:0] status_bits,
  input logic [7:0] clicks
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A click always leaves the clicked event and pressed flag set
  a_click_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && click_fired |-> event_bits[0] && status_bits[0])
    else $error("click without clicked event or pressed flag");

  // Repeating is only reachable while pressed
  a_repeat_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_bits[2] |-> status_bits[0])
    else $error("repeated flag without pressed flag");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clicks) && $stable(event_bits))
    else $error("stalled result changed");

endmodule

bind button_press_repeat_detector bprd_checker u_bprd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .click_fired (click_fired),
  .event_bits  (event_bits),
  .status_bits (status_bits),
  .clicks      (clicks)
);

// File: bench/bprd_poll_checker.sv
// Poll checker: predicts each result of the repeat detector and compares it with the block.
module bprd_poll_checker
  import bprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        pressed_level,
  input  logic [31:0] now_ms,
  input  logic        clear_all,
  input  logic [2:0]  clear_mask,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        click_fired,
  input  logic [2:0]  event_bits,
  input  logic [2:0]  status_bits,
  input  logic [7:0]  clicks,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          in_flight
);

  localparam int MaxReports = 100;

  typedef struct packed {
    logic       fired;
    logic [2:0] evt;
    logic [2:0] st;
    logic [7:0] cnt;
  } poll_result_t;

  // Shadow of the timing registers
  logic [15:0] hold_ms;
  logic [15:0] delay_ms;
  logic [15:0] period_ms;

  // Shadow of the button state
  phase_t      ph;
  logic [31:0] mark_ms;
  logic [2:0]  evt_flags;
  logic [2:0]  st_flags;
  logic [7:0]  click_cnt;

  poll_result_t expected_q[$];
  int           fails = 0;

  assign mismatches = fails;

  // Advance the shadow state by one poll and return what the block should report
  function automatic poll_result_t predict_poll(input logic lvl, input logic [31:0] t,
                                                input logic clr_all, input logic [2:0] clr_mask);
    poll_result_t r;
    logic [31:0]  elapsed;
    logic [15:0]  limit_ms;
    r = '0;
    elapsed = t - mark_ms;
    if (clr_all) evt_flags = 3'b000;
    evt_flags = evt_flags & ~clr_mask;
    case (ph)
      PH_WAIT_REL: begin
        if (!lvl) ph = PH_WAIT_PRS;
      end
      PH_WAIT_PRS: begin
        if (lvl) begin
          ph = PH_QUALIFY;
          mark_ms = t;
          click_cnt = 8'd0;
        end
      end
      PH_QUALIFY: begin
        if (lvl) begin
          if (elapsed >= {16'd0, hold_ms}) begin
            r.fired = 1'b1;
            ph = PH_REP_DELAY;
            mark_ms = t;
            evt_flags[EVT_CLICKED] = 1'b1;
            st_flags[ST_PRESSED] = 1'b1;
            click_cnt = click_cnt + 8'd1;
          end
        end else begin
          ph = PH_WAIT_PRS;
          // A release only counts once a click has been qualified
          if (st_flags[ST_PRESSED]) begin
            evt_flags[EVT_RELEASED] = 1'b1;
            st_flags[ST_RELEASED] = 1'b1;
            st_flags[ST_PRESSED] = 1'b0;
            st_flags[ST_REPEATED] = 1'b0;
          end
        end
      end
      PH_REP_DELAY, PH_REPEAT: begin
        if (lvl) begin
          limit_ms = (ph == PH_REP_DELAY) ? delay_ms : period_ms;
          if (elapsed >= {16'd0, limit_ms}) begin
            r.fired = 1'b1;
            mark_ms = t;
            ph = PH_REPEAT;
            evt_flags[EVT_CLICKED] = 1'b1;
            evt_flags[EVT_REPEATED] = 1'b1;
            st_flags[ST_REPEATED] = 1'b1;
            click_cnt = click_cnt + 8'd1;
          end
        end else begin
          // Drop back to qualify; the release is confirmed on a later poll
          ph = PH_QUALIFY;
          mark_ms = t;
        end
      end
      default: ph = PH_WAIT_REL;
    endcase
    r.evt = evt_flags;
    r.st  = st_flags;
    r.cnt = click_cnt;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Track config writes, queue a prediction per poll, compare each result
  always @(posedge clk) begin
    poll_result_t want;
    if (rst) begin
      hold_ms   = PressHoldReset;
      delay_ms  = RepeatDelayReset;
      period_ms = RepeatPeriodReset;
      ph        = PH_WAIT_REL;
      mark_ms   = 32'd0;
      evt_flags = 3'b000;
      st_flags  = 3'b000;
      click_cnt = 8'd0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PRESS_HOLD:    hold_ms = pwdata[15:0];
          REG_REPEAT_DELAY:  delay_ms = pwdata[15:0];
          REG_REPEAT_PERIOD: period_ms = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_poll(pressed_level, now_ms, clear_all, clear_mask));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $display("%0t: result expected none, got clicks %0d", $time, clicks);
        end else begin
          want = expected_q.pop_front();
          check_field("click_fired", 32'(want.fired), 32'(click_fired));
          check_field("event_bits", 32'(want.evt), 32'(event_bits));
          check_field("status_bits", 32'(want.st), 32'(status_bits));
          check_field("clicks", 32'(want.cnt), 32'(clicks));
        end
      end
    end
    in_flight <= expected_q.size();
  end

endmodule

// File: bench/tb_button_press_repeat_detector.sv
// Testbench top for the button press repeat detector: clock, reset, stimulus and verdict.
module tb_button_press_repeat_detector;
  import bprd_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int TimeoutCycles = 400000;
  localparam int SegItems      = 130;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        pressed_level;
  logic [31:0] now_ms;
  logic        clear_all;
  logic [2:0]  clear_mask;
  logic        out_valid;
  logic        out_ready;
  logic        click_fired;
  logic [2:0]  event_bits;
  logic [2:0]  status_bits;
  logic [7:0]  clicks;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          in_flight;
  int          sent_total = 0;
  bit          idle_en = 1'b1;
  bit          quiet = 1'b0;
  bit          long_hold_done = 1'b0;
  logic [31:0] ms_now = 32'hFFFF_F000;

  button_press_repeat_detector dut (.*);

  bprd_poll_checker checker_i (
    .mismatches(mismatches),
    .in_flight(in_flight),
    .*
  );

  // Clock
  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // Offer one poll item and hold it until taken, then maybe idle
  task automatic send_poll(input logic lvl, input logic [31:0] t, input logic clr_all,
                           input logic [2:0] clr_mask);
    in_valid      <= 1'b1;
    pressed_level <= lvl;
    now_ms        <= t;
    clear_all     <= clr_all;
    clear_mask    <= clr_mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Advance the timestamp by a random step (now and then a wide jump) and send
  task automatic random_poll(input logic lvl, input int unsigned step_max);
    if ($urandom_range(0, 39) == 0) ms_now = ms_now + $urandom();
    else ms_now = ms_now + $urandom_range(0, step_max);
    send_poll(lvl, ms_now, $urandom_range(0, 9) == 0,
              ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd0);
  endtask

  // Mostly release-then-hold gestures of random length, some single noisy polls
  task automatic run_gestures(input int count, input int unsigned step_max);
    int done_items;
    int rel_len;
    int hold_len;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(0, 9) == 0) begin
        random_poll(1'($urandom_range(0, 1)), step_max);
        done_items++;
      end else begin
        rel_len  = $urandom_range(1, 4);
        hold_len = $urandom_range(1, 40);
        repeat (rel_len) random_poll(1'b0, step_max);
        repeat (hold_len) random_poll(1'b1, step_max);
        done_items += rel_len + hold_len;
      end
    end
  endtask

  // APB write; leaves psel high so writes can go back to back
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Drain the block, then load all three timing registers
  task automatic set_timing(input logic [15:0] hold_v, input logic [15:0] delay_v,
                            input logic [15:0] period_v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_PRESS_HOLD, hold_v);
    write_reg(REG_REPEAT_DELAY, delay_v);
    write_reg(REG_REPEAT_PERIOD, period_v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off, none at the end
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && sent_total >= 300) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    pressed_level <= 1'b0;
    now_ms        <= 32'd0;
    clear_all     <= 1'b0;
    clear_mask    <= 3'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 4'd0;
    pwdata        <= 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timing: wait for release, qualify, click, repeat, clears, release
    send_poll(1'b1, 32'd0, 1'b0, 3'd0);
    send_poll(1'b0, 32'd5, 1'b0, 3'd0);
    send_poll(1'b1, 32'd100, 1'b0, 3'd0);
    send_poll(1'b1, 32'd149, 1'b0, 3'd0);
    send_poll(1'b1, 32'd150, 1'b0, 3'd0);
    send_poll(1'b0, 32'd160, 1'b0, 3'd0);
    send_poll(1'b1, 32'd170, 1'b0, 3'd0);
    send_poll(1'b1, 32'd220, 1'b0, 3'd0);
    send_poll(1'b1, 32'd1220, 1'b0, 3'd0);
    send_poll(1'b1, 32'd1320, 1'b1, 3'd0);
    send_poll(1'b1, 32'd1330, 1'b0, 3'd7);
    send_poll(1'b0, 32'd1340, 1'b0, 3'd0);
    send_poll(1'b0, 32'd1341, 1'b0, 3'd2);
    // Press start across the timestamp wrap
    send_poll(1'b1, 32'hFFFF_FFF0, 1'b0, 3'd0);
    send_poll(1'b1, 32'h0000_0030, 1'b0, 3'd0);
    send_poll(1'b0, 32'hFFFF_FFFF, 1'b0, 3'd3);

    // Zero times: every deadline met on the first qualifying poll
    set_timing(16'd0, 16'd0, 16'd0);
    send_poll(1'b0, 32'd1, 1'b0, 3'd0);
    send_poll(1'b1, 32'd2, 1'b0, 3'd0);
    send_poll(1'b1, 32'd2, 1'b0, 3'd0);
    send_poll(1'b1, 32'd2, 1'b0, 3'd0);
    send_poll(1'b1, 32'd2, 1'b1, 3'd5);

    // Largest times
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_poll(1'b0, 32'd10, 1'b0, 3'd0);
    send_poll(1'b0, 32'd11, 1'b0, 3'd0);
    send_poll(1'b1, 32'hFFFF_0000, 1'b0, 3'd0);
    send_poll(1'b1, 32'hFFFF_FFFE, 1'b0, 3'd0);
    send_poll(1'b1, 32'h0000_FFFF, 1'b0, 3'd0);

    // Random gestures under a series of timing settings
    set_timing(16'd5, 16'd30, 16'd10);
    run_gestures(SegItems, 8);
    set_timing(16'd0, 16'd0, 16'd0);
    run_gestures(SegItems, 3);
    set_timing(PressHoldReset, RepeatDelayReset, RepeatPeriodReset);
    run_gestures(SegItems, 60);
    set_timing(16'd20, 16'd100, 16'd0);
    run_gestures(SegItems, 15);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(SegItems, 30000);
    set_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
               16'($urandom_range(0, 40)));
    run_gestures(SegItems, 12);
    set_timing(16'd3, 16'd200, 16'd1);
    run_gestures(SegItems, 10);
    set_timing(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 300)));
    idle_en = 1'b0;
    quiet   = 1'b1;
    run_gestures(SegItems, 40);

    // Drain and decide
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bprd_pkg.sv
rtl/button_press_repeat_detector.sv
rtl/bprd_checker.sv
bench/bprd_poll_checker.sv
bench/tb_button_press_repeat_detector.sv
